// File: sv/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// File: sv/pgod_pkg.sv
// package: widths, constants, types and tables of the omni drive controller
package pgod_pkg;

  // field widths
  localparam int CoordW = 24;
  localparam int GainW  = 16;
  localparam int SumW   = 32;

  // cordic setup
  localparam int CORDIC_STEPS  = 16;
  localparam int FRACTION_BITS = 8;
  localparam int TableLen      = 24;
  localparam int NSteps        = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;
  localparam int ItW           = 5;
  localparam int AngleFrac     = 16;
  localparam int GuardBits     = 8;
  localparam int DW            = 36;
  localparam int ZW            = 26;
  localparam int DegShift      = AngleFrac - FRACTION_BITS;
  localparam int DegRnd        = (DegShift == 0) ? 0 : (1 << (DegShift - 1));

  // datapath widths
  localparam int AW  = 40;
  localparam int PW  = 56;
  localparam int MBW = 16;
  localparam int CntW = 5;

  // fixed-point constants
  localparam logic [MBW-1:0] GainQ16  = 16'd39796;
  localparam logic [MBW-1:0] DtQ16    = 16'd1311;
  localparam logic [MBW-1:0] Cos30Q16 = 16'd56756;
  localparam logic [MBW-1:0] ScaleQ16 = 16'd56756;
  localparam logic signed [ZW-1:0] HalfTurn = 26'sd11796480;
  localparam logic signed [ZW-1:0] Quarter  = 26'sd5898240;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_KP  = 3'd0,
    REG_KI  = 3'd1,
    REG_KD  = 3'd2,
    REG_THR = 3'd3
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEC,
    ST_MUL,
    ST_ROT,
    ST_DONE
  } state_t;

  // products run on the shared multiplier, in order
  typedef enum logic [3:0] {
    OP_DIST,
    OP_DT,
    OP_KP,
    OP_KI,
    OP_KD,
    OP_GX,
    OP_GY,
    OP_MIX,
    OP_D1,
    OP_D2,
    OP_D3
  } mul_op_t;

  typedef struct packed {
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
    logic signed [CoordW-1:0] measured_x;
    logic signed [CoordW-1:0] measured_y;
    logic                     restart;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] drive_one;
    logic signed [CoordW-1:0] drive_two;
    logic signed [CoordW-1:0] drive_three;
    logic                     arrived;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic signed [AW-1:0] a;
    logic [MBW-1:0]       b;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [PW-1:0] p;
  } mul_rsp_t;

  // arctangent of 2^-i in degrees, 16 fraction bits
  function automatic logic signed [ZW-1:0] atan_lut(input logic [ItW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/pgod_smul.sv
// bit-serial shift-add multiplier: signed operand times unsigned 16-bit operand
module pgod_smul
  import pgod_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic signed [AW-1:0] a_r;
  logic [MBW-1:0]       b_r;
  logic signed [PW-1:0] acc_r, acc_nxt;
  logic [CntW-1:0]      cnt_r;
  logic                 busy_r, done_r;

  // one multiplier bit per cycle, msb first
  always_comb begin
    acc_nxt = (acc_r <<< 1) + (b_r[MBW-1] ? PW'(a_r) : PW'(0));
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(MBW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand shift registers and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= $signed(req.a);
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      b_r   <= b_r << 1;
      acc_r <= acc_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

// File: sv/pid_goto_omni_drive.sv
// top level: point-to-point pid controller for a three-wheel omni base
//
//  channel   direction  handshake             payload
//  in_       input      in_valid / in_stall   in_item_t (target, measured, restart)
//  out_      output     out_valid / out_stall out_item_t (three drives, arrived)
//  cfg_      input      cfg_we                cfg_index, cfg_wdata (16 bits)
//
// one item at a time: the result is loaded after the distance product when the target is
// reached and after the last drive product otherwise; the next transfer can be taken in
// the cycle after the load. 16 vectoring and 16 rotation cordic iterations, one per cycle,
// and up to 11 products on the shift-add multiplier (start, 16 bit steps, consume).
// rst_n is synchronous; it restores the default gains and clears position and pid state.
// a finished result sits in the output register, so a new transfer is taken while it waits.
`include "assert_macros.svh"

module pid_goto_omni_drive
  import pgod_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [GainW-1:0]     cfg_wdata
);

  state_t  state_r, state_nxt;
  mul_op_t op_r;

  // configuration
  logic [GainW-1:0] kp_r, ki_r, kd_r, thr_r;

  // controller state
  logic signed [CoordW-1:0] pos_x_r, pos_y_r;
  logic [SumW-1:0]          err_sum_r;
  logic [CoordW-1:0]        last_err_r;

  // per-item working registers
  logic signed [CoordW-1:0] mx_r, my_r;
  logic signed [DW-1:0]     x_r, y_r;
  logic signed [ZW-1:0]     z_r, angle_r;
  logic [ItW-1:0]           it_r;
  logic [CoordW-1:0]        err_r;
  logic signed [30:0]       deriv_r;
  logic signed [PW-1:0]     pid_acc_r;
  logic                     neg_r;
  logic signed [AW-1:0]     vy_r, vx_r, m1_r, m2_r, m3_r;
  logic signed [CoordW-1:0] d1_r, d2_r, d3_r;
  logic                     arr_r;
  logic                     pend_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  // handshake and sequencing strobes
  logic     in_fire, mul_start, out_load, step_last;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  pgod_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // cordic micro-rotation, shared by vectoring and rotation
  logic signed [DW-1:0] xs_w, ys_w, x_nxt, y_nxt;
  logic signed [ZW-1:0] at_w, z_nxt;
  logic                 dir_w;

  always_comb begin
    xs_w  = x_r >>> it_r;
    ys_w  = y_r >>> it_r;
    at_w  = atan_lut(it_r);
    dir_w = (state_r == ST_ROT) ? !z_r[ZW-1] : !(!y_r[DW-1] && (y_r != '0));
    if (dir_w) begin
      x_nxt = x_r - ys_w;
      y_nxt = y_r + xs_w;
      z_nxt = z_r - at_w;
    end else begin
      x_nxt = x_r + ys_w;
      y_nxt = y_r - xs_w;
      z_nxt = z_r + at_w;
    end
  end

  // start vector from stored position to target
  logic signed [CoordW-1:0] px_eff, py_eff;
  logic signed [CoordW:0]   dx_w, dy_w;
  logic signed [DW-1:0]     gx_w, gy_w;

  always_comb begin
    px_eff = in_data.restart ? '0 : pos_x_r;
    py_eff = in_data.restart ? '0 : pos_y_r;
    dx_w   = (CoordW+1)'($signed(in_data.target_x)) - (CoordW+1)'(px_eff);
    dy_w   = (CoordW+1)'($signed(in_data.target_y)) - (CoordW+1)'(py_eff);
    gx_w   = DW'(dx_w) <<< GuardBits;
    gy_w   = DW'(dy_w) <<< GuardBits;
  end

  // product post-processing
  logic signed [PW-1:0]     mp_w, rnd16_w, dist_w, pid_sum_w, pid_rnd_w, h_w, t2_w, t3_w;
  logic                     go_on;
  logic [CoordW-1:0]        err_w;
  logic [SumW:0]            sum_w;
  logic [SumW-1:0]          sum_sat_w;
  logic signed [CoordW:0]   diff_w;
  logic signed [30:0]       diff31_w;
  logic signed [31:0]       pid_w;
  logic signed [ZW-1:0]     z0_w;
  logic                     neg0_w;
  logic signed [AW-1:0]     g_w, gn_w, degv_w;
  logic signed [ZW:0]       degv_full;
  logic signed [CoordW-1:0] drv_w;

  always_comb begin
    mp_w     = $signed(mul_rsp.p);
    rnd16_w  = (mp_w + (PW'(1) <<< 15)) >>> 16;
    dist_w   = (mp_w + (PW'(1) <<< 23)) >>> 24;
    go_on    = dist_w > $signed(PW'(thr_r));
    err_w    = (dist_w > PW'(64'sd8388607)) ? 24'd8388607 : dist_w[CoordW-1:0];

    // integral with saturation, derivative times 1/dt
    sum_w     = {1'b0, err_sum_r} + rnd16_w[SumW:0];
    sum_sat_w = (sum_w > (SumW+1)'(33'd2147483647)) ? 32'd2147483647 : sum_w[SumW-1:0];
    diff_w    = $signed({1'b0, err_r}) - $signed({1'b0, last_err_r});
    diff31_w  = 31'(diff_w);

    // pid output rounded and clamped to 32 bits
    pid_sum_w = pid_acc_r + mp_w;
    pid_rnd_w = (pid_sum_w + PW'(2048)) >>> 12;
    if (pid_rnd_w > PW'(64'sd2147483647)) begin
      pid_w = 32'sh7fffffff;
    end else if (pid_rnd_w < PW'(-64'sd2147483648)) begin
      pid_w = 32'sh80000000;
    end else begin
      pid_w = pid_rnd_w[31:0];
    end

    // fold bearing into the right half-plane for rotation
    if (angle_r > Quarter) begin
      z0_w   = angle_r - HalfTurn;
      neg0_w = 1'b1;
    end else if (angle_r < -Quarter) begin
      z0_w   = angle_r + HalfTurn;
      neg0_w = 1'b1;
    end else begin
      z0_w   = angle_r;
      neg0_w = 1'b0;
    end

    // gain-corrected rotation outputs
    g_w  = rnd16_w[AW-1:0];
    gn_w = neg_r ? -g_w : g_w;

    // bearing in degrees at output precision
    degv_full = ((ZW+1)'(angle_r) + (ZW+1)'(DegRnd)) >>> DegShift;
    degv_w    = AW'(degv_full);

    // wheel mix
    h_w  = PW'(vy_r) <<< 15;
    t2_w = (mp_w - h_w + (PW'(1) <<< 15)) >>> 16;
    t3_w = ((-h_w) - mp_w + (PW'(1) <<< 15)) >>> 16;

    // drive scale and clamp
    if (rnd16_w > PW'(64'sd8388607)) begin
      drv_w = 24'sh7fffff;
    end else if (rnd16_w < PW'(-64'sd8388608)) begin
      drv_w = 24'sh800000;
    end else begin
      drv_w = rnd16_w[CoordW-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_VEC;
      end
      ST_VEC: begin
        if (step_last) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          case (op_r)
            OP_DIST: if (!go_on) state_nxt = ST_DONE;
            OP_KD:   state_nxt = ST_ROT;
            OP_D3:   state_nxt = ST_DONE;
            default: state_nxt = ST_MUL;
          endcase
        end
      end
      ST_ROT: begin
        if (step_last) state_nxt = ST_MUL;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    in_fire   = in_valid && !in_stall;
    step_last = (it_r == ItW'(NSteps - 1));
    mul_start = (state_r == ST_MUL) && !pend_r;
    out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
    mul_req.start = mul_start;
    case (op_r)
      OP_DIST: begin mul_req.a = AW'(x_r);                      mul_req.b = GainQ16;  end
      OP_DT:   begin mul_req.a = AW'($signed({1'b0, err_r}));   mul_req.b = DtQ16;    end
      OP_KP:   begin mul_req.a = AW'($signed({1'b0, err_r}));   mul_req.b = kp_r;     end
      OP_KI:   begin mul_req.a = AW'($signed({1'b0, err_sum_r})); mul_req.b = ki_r;   end
      OP_KD:   begin mul_req.a = AW'(deriv_r);                  mul_req.b = kd_r;     end
      OP_GX:   begin mul_req.a = AW'(x_r);                      mul_req.b = GainQ16;  end
      OP_GY:   begin mul_req.a = AW'(y_r);                      mul_req.b = GainQ16;  end
      OP_MIX:  begin mul_req.a = vx_r;                          mul_req.b = Cos30Q16; end
      OP_D1:   begin mul_req.a = m1_r;                          mul_req.b = ScaleQ16; end
      OP_D2:   begin mul_req.a = m2_r;                          mul_req.b = ScaleQ16; end
      OP_D3:   begin mul_req.a = m3_r;                          mul_req.b = ScaleQ16; end
      default: begin mul_req.a = '0;                            mul_req.b = '0;       end
    endcase
  end

  // control state, configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      kp_r        <= 16'd4096;
      ki_r        <= 16'd41;
      kd_r        <= 16'd205;
      thr_r       <= 16'd26;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      err_sum_r   <= '0;
      last_err_r  <= '0;
    end else begin
      state_r <= state_nxt;

      if (mul_start) pend_r <= 1'b1;
      else if (mul_rsp.done) pend_r <= 1'b0;

      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_KP:  kp_r  <= cfg_wdata;
          REG_KI:  ki_r  <= cfg_wdata;
          REG_KD:  kd_r  <= cfg_wdata;
          REG_THR: thr_r <= cfg_wdata;
          default: ;
        endcase
      end

      // restart clears the stored position
      if (in_fire && in_data.restart) begin
        pos_x_r <= '0;
        pos_y_r <= '0;
      end

      if ((state_r == ST_MUL) && mul_rsp.done) begin
        if (op_r == OP_DT) begin
          err_sum_r  <= sum_sat_w;
          last_err_r <= err_r;
        end
        // latch the measured position once drives are out
        if (op_r == OP_D3) begin
          pos_x_r <= mx_r;
          pos_y_r <= my_r;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mx_r  <= $signed(in_data.measured_x);
      my_r  <= $signed(in_data.measured_y);
      it_r  <= '0;
      op_r  <= OP_DIST;
      arr_r <= 1'b0;
      if (gx_w[DW-1]) begin
        x_r <= -gx_w;
        y_r <= -gy_w;
        z_r <= gy_w[DW-1] ? -HalfTurn : HalfTurn;
      end else begin
        x_r <= gx_w;
        y_r <= gy_w;
        z_r <= '0;
      end
    end

    // cordic iterations
    if ((state_r == ST_VEC) || (state_r == ST_ROT)) begin
      if (state_r == ST_VEC) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
      end else begin
        x_r <= x_nxt;
        y_r <= y_nxt;
      end
      z_r  <= z_nxt;
      it_r <= step_last ? '0 : it_r + 1'b1;
      if ((state_r == ST_VEC) && step_last) angle_r <= z_nxt;
    end

    // consume each product
    if ((state_r == ST_MUL) && mul_rsp.done) begin
      case (op_r)
        OP_DIST: begin
          err_r <= err_w;
          op_r  <= OP_DT;
          if (!go_on) begin
            arr_r <= 1'b1;
            d1_r  <= '0;
            d2_r  <= '0;
            d3_r  <= '0;
          end
        end
        OP_DT: begin
          deriv_r <= diff31_w * 31'sd50;
          op_r    <= OP_KP;
        end
        OP_KP: begin
          pid_acc_r <= mp_w;
          op_r      <= OP_KI;
        end
        OP_KI: begin
          pid_acc_r <= pid_sum_w;
          op_r      <= OP_KD;
        end
        OP_KD: begin
          x_r   <= DW'(pid_w);
          y_r   <= '0;
          z_r   <= z0_w;
          neg_r <= neg0_w;
          it_r  <= '0;
          op_r  <= OP_GX;
        end
        OP_GX: begin
          vy_r <= gn_w;
          op_r <= OP_GY;
        end
        OP_GY: begin
          vx_r <= gn_w;
          m1_r <= vy_r + degv_w;
          op_r <= OP_MIX;
        end
        OP_MIX: begin
          m2_r <= AW'(t2_w) + degv_w;
          m3_r <= AW'(t3_w) + degv_w;
          op_r <= OP_D1;
        end
        OP_D1: begin
          d1_r <= drv_w;
          op_r <= OP_D2;
        end
        OP_D2: begin
          d2_r <= drv_w;
          op_r <= OP_D3;
        end
        OP_D3: begin
          d3_r <= drv_w;
        end
        default: ;
      endcase
    end

    // result register
    if (out_load) begin
      out_data_r.drive_one   <= d1_r;
      out_data_r.drive_two   <= d2_r;
      out_data_r.drive_three <= d3_r;
      out_data_r.arrived     <= arr_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `ASSERT_IMP(a_arrived_zero, out_valid && out_data.arrived, (out_data.drive_one == '0) && (out_data.drive_two == '0) && (out_data.drive_three == '0))
  `ASSERT_IMP(a_pend_in_mul, pend_r, state_r == ST_MUL)
  `ASSERT_ALWAYS(a_sum_nonneg, !err_sum_r[SumW-1])

endmodule

// File: verif/pid_goto_omni_drive_test.sv
// self-checking testbench of the omni drive pid controller
module pid_goto_omni_drive_test;
  import pgod_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // arctangent of 2^-i in degrees with 16 fraction bits
  localparam longint AtanDeg [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // shift right with round half up
  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [CoordW-1:0] wheel_drive(longint m);
    return CoordW'(clamp(round_shift(m * 56756, 16), -8388608, 8388607));
  endfunction

  // controller predictor: gains, stored position and pid state
  class drive_scoreboard;
    longint kp, ki, kd, thr;
    longint pos_x, pos_y, err_sum, prev_err;
    out_item_t pending[$];
    int errors;

    function void clear();
      kp = 4096; ki = 41; kd = 205; thr = 26;
      pos_x = 0; pos_y = 0; err_sum = 0; prev_err = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_KP:  kp = val;
        REG_KI:  ki = val;
        REG_KD:  kd = val;
        REG_THR: thr = val;
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // work out the drives of one accepted transfer
    function void note_tick(in_item_t it);
      longint x, y, z, xs, ys, mag, distance, err, deriv, pid, vx, vy, deg;
      longint m1, m2, m3;
      bit flip;
      out_item_t r;
      if (it.restart) begin
        pos_x = 0; pos_y = 0;
      end
      x = (longint'(it.target_x) - pos_x) * 256;
      y = (longint'(it.target_y) - pos_y) * 256;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? (longint'(180) << 16) : -(longint'(180) << 16);
        x = -x; y = -y;
      end
      for (int i = 0; i < NSteps; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += AtanDeg[i];
        end else begin
          x -= ys; y += xs; z -= AtanDeg[i];
        end
      end
      mag = x;
      distance = round_shift(mag * 39796, 24);
      r = '0;
      if (distance > thr) begin
        err = clamp(distance, 0, 8388607);
        err_sum = clamp(err_sum + round_shift(err * 1311, 16), 0, 2147483647);
        deriv = (err - prev_err) * 50;
        pid = kp * err + ki * err_sum + kd * deriv;
        pid = clamp(round_shift(pid, 12), longint'(-2147483647) - 1, 2147483647);
        prev_err = err;
        // resolve the pid output along the bearing
        x = pid; y = 0; flip = 0;
        deg = z;
        if (deg > (longint'(90) << 16)) begin
          deg -= longint'(180) << 16; flip = 1;
        end else if (deg < -(longint'(90) << 16)) begin
          deg += longint'(180) << 16; flip = 1;
        end
        for (int i = 0; i < NSteps; i++) begin
          xs = x >>> i; ys = y >>> i;
          if (deg >= 0) begin
            x -= ys; y += xs; deg -= AtanDeg[i];
          end else begin
            x += ys; y -= xs; deg += AtanDeg[i];
          end
        end
        vy = round_shift(x * 39796, 16);
        vx = round_shift(y * 39796, 16);
        if (flip) begin
          vy = -vy; vx = -vx;
        end
        deg = round_shift(z, 16 - FRACTION_BITS);
        m1 = vy + deg;
        m2 = round_shift(-vy * 32768 + vx * 56756, 16) + deg;
        m3 = round_shift(-vy * 32768 - vx * 56756, 16) + deg;
        r.drive_one = wheel_drive(m1);
        r.drive_two = wheel_drive(m2);
        r.drive_three = wheel_drive(m3);
        pos_x = it.measured_x;
        pos_y = it.measured_y;
      end else begin
        r.arrived = 1'b1;
      end
      pending.push_back(r);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.drive_one !== want.drive_one)
        report_mismatch($sformatf("drive_one %0d want %0d", got.drive_one, want.drive_one));
      if (got.drive_two !== want.drive_two)
        report_mismatch($sformatf("drive_two %0d want %0d", got.drive_two, want.drive_two));
      if (got.drive_three !== want.drive_three)
        report_mismatch($sformatf("drive_three %0d want %0d", got.drive_three,
                                  want.drive_three));
      if (got.arrived !== want.arrived)
        report_mismatch($sformatf("arrived %0b want %0b", got.arrived, want.arrived));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [GainW-1:0] cfg_wdata;

  drive_scoreboard board;

  pid_goto_omni_drive uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // short gaps mostly, now and then a long one, sometimes none at all
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // one transfer on the input channel; valid stays up for a back-to-back follower
  task automatic send_tick(in_item_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_tick(it);
    @(negedge clk);
  endtask

  // drop valid, wait until every expected result has come, then idle a while
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return 24'($urandom_range(0, 60)) - 24'sd30;
      3: return 24'($urandom_range(0, 8000)) - 24'sd4000;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic in_item_t rand_tick();
    in_item_t it;
    it.target_x = rand_coord();
    it.target_y = rand_coord();
    it.measured_x = rand_coord();
    it.measured_y = rand_coord();
    it.restart = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  function automatic in_item_t make_tick(int tx, int ty, int mx, int my, bit rs);
    in_item_t it;
    it.target_x = CoordW'(tx); it.target_y = CoordW'(ty);
    it.measured_x = CoordW'(mx); it.measured_y = CoordW'(my);
    it.restart = rs;
    return it;
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  // result side: random stall, check on every transfer
  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < 8) ? 1'b1 : (gap_len() > 2);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // stimulus
  initial begin
    board = new();
    board.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_KP;
    cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: arrival, zero vector, extremes, each quadrant, restart
    send_tick(make_tick(0, 0, 0, 0, 0));
    send_tick(make_tick(26, 0, 5, 5, 0));
    send_tick(make_tick(27, 0, 5, 5, 0));
    send_tick(make_tick(1000, 1000, 100, 200, 0));
    send_tick(make_tick(-1000, 500, -50, 60, 0));
    send_tick(make_tick(-1000, -500, 0, 0, 1));
    send_tick(make_tick(-1000, 0, 0, 0, 1));
    send_tick(make_tick(800, -900, 10, -10, 0));
    send_tick(make_tick(8388607, 8388607, -8388608, -8388608, 0));
    send_tick(make_tick(8388607, 8388607, -8388608, 8388607, 0));
    send_tick(make_tick(-8388608, -8388608, 8388607, 8388607, 0));
    send_tick(make_tick(-8388608, 8388607, 0, 0, 1));
    send_tick(make_tick(0, -8388608, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 0, 1));
    drain();
    // extreme gains drive integral and output saturation
    write_reg(REG_KP, 16'hffff);
    write_reg(REG_KI, 16'hffff);
    write_reg(REG_KD, 16'hffff);
    write_reg(REG_THR, 16'd0);
    for (int i = 0; i < 8; i++)
      send_tick(make_tick(8388607, -8388608, -8388608, 8388607, 1));
    send_tick(make_tick(1, 0, 0, 0, 1));
    drain();
    write_reg(REG_KP, 16'd0);
    write_reg(REG_KI, 16'd0);
    write_reg(REG_KD, 16'd0);
    write_reg(REG_THR, 16'hffff);
    send_tick(make_tick(200, 200, 0, 0, 1));
    send_tick(make_tick(-8388608, 0, 0, 0, 1));

    // random phases with fresh settings between them
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      write_reg(REG_KP, rand_gain());
      write_reg(REG_KI, rand_gain());
      write_reg(REG_KD, rand_gain());
      write_reg(REG_THR, (ph % 3 == 0) ? 16'($urandom()) : 16'($urandom_range(0, 200)));
      for (int n = 0; n < 140; n++) send_tick(rand_tick());
    end
    drain();
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+sv
sv/pgod_pkg.sv
sv/pgod_smul.sv
sv/pid_goto_omni_drive.sv
verif/pid_goto_omni_drive_test.sv
